// ===== design/v2pa_pkg.sv =====
package v2pa_pkg;

  // Input coordinate width (signed Q7.16 metres)
  localparam int IN_W = 24;

  // Angle formats: table and accumulator carry 24 fraction bits
  localparam int CORDIC_ITERATIONS = 16;
  localparam int ANGLE_FRAC_BITS   = 7;
  localparam int TAB_FRAC          = 24;
  localparam int TAB_LEN           = 32;
  localparam int TAB_IDX_W         = 5;
  localparam int NCELL = (CORDIC_ITERATIONS > TAB_LEN) ? TAB_LEN : CORDIC_ITERATIONS;

  // CORDIC datapath widths: vectors up to about 2^32.5, angle below 2^32
  localparam int CV_W = 36;
  localparam int ZW   = 34;

  // Rounding to the output angle format
  localparam int RND_SHIFT = TAB_FRAC - ANGLE_FRAC_BITS;
  localparam logic signed [ZW-1:0] RND_HALF = ZW'(64'd1 << (RND_SHIFT - 1));
  localparam logic signed [ZW-1:0] QUARTER  = ZW'(64'd90 << TAB_FRAC);
  localparam logic signed [ZW-1:0] LIM180   = ZW'(64'd180 << ANGLE_FRAC_BITS);
  localparam logic signed [ZW-1:0] LIM90    = ZW'(64'd90 << ANGLE_FRAC_BITS);

  // Square root of (x*x + z*z) << 16, one result bit per cell
  localparam int SQ_W     = 2 * IN_W - 1;
  localparam int SUM_W    = 2 * IN_W;
  localparam int RAD_W    = SUM_W + 16;
  localparam int ROOT_W   = RAD_W / 2;
  localparam int REM_W    = ROOT_W + 2;
  localparam int FRONT_DLY = ROOT_W + 2;

  // Output field widths
  localparam int YAW_W   = 16;
  localparam int PITCH_W = 15;
  localparam int ROLL_W  = 16;

  typedef struct packed {
    logic signed [CV_W-1:0] vx;
    logic signed [CV_W-1:0] vy;
    logic signed [ZW-1:0]   z;
  } cordic_vec_t;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    logic [RAD_W-1:0]  rad;
  } sqrt_vec_t;

  // atan(2^-i) in degrees, 24 fraction bits
  localparam logic [30:0] ATAN_TAB [TAB_LEN] = '{
    31'd754974720, 31'd445687602, 31'd235489088, 31'd119537938,
    31'd60000934,  31'd30029717,  31'd15018523,  31'd7509720,
    31'd3754917,   31'd1877466,   31'd938734,    31'd469367,
    31'd234684,    31'd117342,    31'd58671,     31'd29335,
    31'd14668,     31'd7334,      31'd3667,      31'd1833,
    31'd917,       31'd458,       31'd229,       31'd115,
    31'd57,        31'd29,        31'd14,        31'd7,
    31'd4,         31'd2,         31'd1,         31'd0
  };

  function automatic logic signed [ZW-1:0] atan_entry(input logic [TAB_IDX_W-1:0] idx);
    atan_entry = $signed({{(ZW-31){1'b0}}, ATAN_TAB[idx]});
  endfunction

endpackage

// ===== design/v2pa_sqrt_cell.sv =====
module v2pa_sqrt_cell
  import v2pa_pkg::*;
(
  input  logic      clk,
  input  sqrt_vec_t d,
  output sqrt_vec_t q
);

  logic [REM_W+1:0] rem_sh;
  logic [REM_W+1:0] trial;
  logic             take;
  sqrt_vec_t        q_nxt;
  sqrt_vec_t        q_r;

  // Bring down the next two radicand bits and try the next root bit
  always_comb begin
    rem_sh = {d.rem, d.rad[RAD_W-1 -: 2]};
    trial  = {2'b00, d.root, 2'b01};
    take   = (rem_sh >= trial);
    q_nxt.rad = {d.rad[RAD_W-3:0], 2'b00};
    if (take) begin
      q_nxt.rem  = REM_W'(rem_sh - trial);
      q_nxt.root = {d.root[ROOT_W-2:0], 1'b1};
    end else begin
      q_nxt.rem  = rem_sh[REM_W-1:0];
      q_nxt.root = {d.root[ROOT_W-2:0], 1'b0};
    end
  end

  // Hand the partial root to the next cell
  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q = q_r;

endmodule

// ===== design/v2pa_cordic_cell.sv =====
module v2pa_cordic_cell
  import v2pa_pkg::*;
(
  input  logic                 clk,
  input  logic [TAB_IDX_W-1:0] idx,
  input  cordic_vec_t          d,
  output cordic_vec_t          q
);

  logic signed [CV_W-1:0] vx;
  logic signed [CV_W-1:0] vy;
  logic signed [CV_W-1:0] sx;
  logic signed [CV_W-1:0] sy;
  logic signed [ZW-1:0]   step;
  cordic_vec_t            q_nxt;
  cordic_vec_t            q_r;

  // Rotate towards the x axis; hold once y has reached zero
  always_comb begin
    vx   = d.vx;
    vy   = d.vy;
    sx   = vx >>> idx;
    sy   = vy >>> idx;
    step = atan_entry(idx);
    q_nxt = d;
    if (vy > 0) begin
      q_nxt.vx = vx + sy;
      q_nxt.vy = vy - sx;
      q_nxt.z  = d.z + step;
    end else if (vy < 0) begin
      q_nxt.vx = vx - sy;
      q_nxt.vy = vy + sx;
      q_nxt.z  = d.z - step;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q = q_r;

endmodule

// ===== design/v2pa_atan2.sv =====
module v2pa_atan2
  import v2pa_pkg::*;
(
  input  logic                   clk,
  input  logic signed [CV_W-1:0] vec_a,
  input  logic signed [CV_W-1:0] vec_b,
  output logic signed [ZW-1:0]   angle
);

  cordic_vec_t          pre_nxt;
  cordic_vec_t          pre_r;
  cordic_vec_t          stage [NCELL+1];
  logic signed [ZW-1:0] angle_nxt;
  logic signed [ZW-1:0] angle_r;

  // Pre-rotate by a quarter turn when the vector lies in the left half plane
  always_comb begin
    pre_nxt.vx = vec_b;
    pre_nxt.vy = vec_a;
    pre_nxt.z  = '0;
    if (vec_b < 0) begin
      if (vec_a >= 0) begin
        pre_nxt.vx = vec_a;
        pre_nxt.vy = -vec_b;
        pre_nxt.z  = QUARTER;
      end else begin
        pre_nxt.vx = -vec_a;
        pre_nxt.vy = vec_b;
        pre_nxt.z  = -QUARTER;
      end
    end
  end

  always_ff @(posedge clk) begin
    pre_r <= pre_nxt;
  end

  assign stage[0] = pre_r;

  // Row of micro-rotation cells, one table entry each
  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    v2pa_cordic_cell u_cell (
      .clk (clk),
      .idx (TAB_IDX_W'(i)),
      .d   (stage[i]),
      .q   (stage[i+1])
    );
  end

  // Round half up to the output angle format
  always_comb begin
    angle_nxt = (stage[NCELL].z + RND_HALF) >>> RND_SHIFT;
  end

  always_ff @(posedge clk) begin
    angle_r <= angle_nxt;
  end

  assign angle = angle_r;

endmodule

// ===== design/vector_to_pointing_angles_core.sv =====
// Channel   Ports                                          Handshake
// input     in_pos_x, in_pos_y, in_pos_z                   start high, busy low
// result    out_yaw_deg, out_pitch_deg, out_roll_deg,      out_valid, one cycle
//           out_zero_vector
//
// One item is taken every cycle; busy stays low.
// The path runs through registered squaring and summing, 32 square-root
// cells, then the pitch CORDIC row.
// Yaw and roll run their CORDIC rows at once and wait in a delay line.
// Reset clears only the valid chain; the datapath holds no item state.
// Results appear for one cycle each and cannot be held off.
module vector_to_pointing_angles_core
  import v2pa_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic signed [IN_W-1:0]    in_pos_x,
  input  logic signed [IN_W-1:0]    in_pos_y,
  input  logic signed [IN_W-1:0]    in_pos_z,
  output logic                      out_valid,
  output logic signed [YAW_W-1:0]   out_yaw_deg,
  output logic signed [PITCH_W-1:0] out_pitch_deg,
  output logic signed [ROLL_W-1:0]  out_roll_deg,
  output logic                      out_zero_vector
);

  localparam int LAT  = NCELL + 37;
  localparam int ZDLY = NCELL + 2;

  logic                      accept;
  logic [LAT-1:0]            vld_r;

  logic signed [2*IN_W-1:0]  prod_x;
  logic signed [2*IN_W-1:0]  prod_z;
  logic [SQ_W-1:0]           sq_x_r;
  logic [SQ_W-1:0]           sq_z_r;
  logic [SUM_W-1:0]          sum_r;
  sqrt_vec_t                 sq_stage [ROOT_W+1];
  logic signed [IN_W-1:0]    y_dly_r [FRONT_DLY];

  logic signed [CV_W-1:0]    yaw_a;
  logic signed [CV_W-1:0]    yaw_b;
  logic signed [CV_W-1:0]    roll_a;
  logic signed [CV_W-1:0]    pitch_a;
  logic signed [CV_W-1:0]    pitch_b;
  logic signed [ZW-1:0]      yaw_ang;
  logic signed [ZW-1:0]      roll_ang;
  logic signed [ZW-1:0]      pitch_ang;
  logic signed [ZW-1:0]      yaw_sat;
  logic signed [ZW-1:0]      roll_sat;
  logic signed [ZW-1:0]      pitch_sat;
  logic                      zero_in;
  logic [ZDLY-1:0]           zero_dly_r;
  logic [YAW_W-1:0]          yaw_dly_r  [FRONT_DLY];
  logic [ROLL_W-1:0]         roll_dly_r [FRONT_DLY];

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  // Advance the valid chain alongside the datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[LAT-2:0], accept};
    end
  end

  // Square x and z, then sum
  assign prod_x = (2*IN_W)'(in_pos_x) * (2*IN_W)'(in_pos_x);
  assign prod_z = (2*IN_W)'(in_pos_z) * (2*IN_W)'(in_pos_z);

  always_ff @(posedge clk) begin
    sq_x_r <= prod_x[SQ_W-1:0];
    sq_z_r <= prod_z[SQ_W-1:0];
    sum_r  <= {1'b0, sq_x_r} + {1'b0, sq_z_r};
  end

  // Horizontal distance: one root bit per cell
  assign sq_stage[0].rem  = '0;
  assign sq_stage[0].root = '0;
  assign sq_stage[0].rad  = {sum_r, 16'd0};

  for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
    v2pa_sqrt_cell u_sqrt (
      .clk (clk),
      .d   (sq_stage[k]),
      .q   (sq_stage[k+1])
    );
  end

  // Hold y until the distance is ready
  always_ff @(posedge clk) begin
    y_dly_r[0] <= in_pos_y;
    for (int k = 1; k < FRONT_DLY; k++) begin
      y_dly_r[k] <= y_dly_r[k-1];
    end
  end

  // Yaw and roll straight from the ports
  assign yaw_a  = {{(CV_W-IN_W){in_pos_x[IN_W-1]}}, in_pos_x};
  assign yaw_b  = {{(CV_W-IN_W){in_pos_z[IN_W-1]}}, in_pos_z};
  assign roll_a = {{(CV_W-IN_W){in_pos_y[IN_W-1]}}, in_pos_y};

  v2pa_atan2 u_yaw (
    .clk   (clk),
    .vec_a (yaw_a),
    .vec_b (yaw_b),
    .angle (yaw_ang)
  );

  v2pa_atan2 u_roll (
    .clk   (clk),
    .vec_a (roll_a),
    .vec_b (yaw_a),
    .angle (roll_ang)
  );

  // Pitch: y with 8 extra fraction bits against the distance
  assign pitch_a = {{(CV_W-IN_W-8){y_dly_r[FRONT_DLY-1][IN_W-1]}},
                    y_dly_r[FRONT_DLY-1], 8'd0};
  assign pitch_b = {{(CV_W-ROOT_W){1'b0}}, sq_stage[ROOT_W].root};
  assign zero_in = (y_dly_r[FRONT_DLY-1] == '0) && (sq_stage[ROOT_W].root == '0);

  v2pa_atan2 u_pitch (
    .clk   (clk),
    .vec_a (pitch_a),
    .vec_b (pitch_b),
    .angle (pitch_ang)
  );

  // Saturate the residual overshoot
  always_comb begin
    yaw_sat = yaw_ang;
    if (yaw_ang > LIM180) yaw_sat = LIM180;
    if (yaw_ang < -LIM180) yaw_sat = -LIM180;
    roll_sat = roll_ang;
    if (roll_ang > LIM180) roll_sat = LIM180;
    if (roll_ang < -LIM180) roll_sat = -LIM180;
    pitch_sat = pitch_ang;
    if (pitch_ang > LIM90) pitch_sat = LIM90;
    if (pitch_ang < -LIM90) pitch_sat = -LIM90;
  end

  // Delay yaw, roll and the zero flag to meet pitch
  always_ff @(posedge clk) begin
    yaw_dly_r[0]  <= yaw_sat[YAW_W-1:0];
    roll_dly_r[0] <= roll_sat[ROLL_W-1:0];
    for (int k = 1; k < FRONT_DLY; k++) begin
      yaw_dly_r[k]  <= yaw_dly_r[k-1];
      roll_dly_r[k] <= roll_dly_r[k-1];
    end
    zero_dly_r <= {zero_dly_r[ZDLY-2:0], zero_in};
  end

  // Register the result item
  always_ff @(posedge clk) begin
    out_yaw_deg     <= yaw_dly_r[FRONT_DLY-1];
    out_roll_deg    <= roll_dly_r[FRONT_DLY-1];
    out_pitch_deg   <= zero_dly_r[ZDLY-1] ? '0 : pitch_sat[PITCH_W-1:0];
    out_zero_vector <= zero_dly_r[ZDLY-1];
  end

  assign out_valid = vld_r[LAT-1];

  // Every result traces back to an accepted item
  a_result_from_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, LAT))
    else $error("result without a matching item");

  // A zero vector gives zero for all three angles
  a_zero_angles: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_zero_vector) |->
      (out_pitch_deg == '0 && out_yaw_deg == '0 && out_roll_deg == '0))
    else $error("zero vector with non-zero angle");

  // The zero flag follows the item's coordinates
  a_zero_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_zero_vector ==
      $past(in_pos_x == '0 && in_pos_y == '0 && in_pos_z == '0, LAT)))
    else $error("zero flag does not match item");

endmodule
